// ===== hw/rtl/bmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhq_pkg: shared types and codes for the binary max heap queue
// Request and status codes, read address selects, and the command/status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_ROOT,
    S_DN_LAST,
    S_DN_GRAB,
    S_DN_CHK,
    S_DN_RR,
    S_DN_CMP,
    S_FIN_RD,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    RD_ROOT,
    RD_LAST,
    RD_PARENT,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  typedef struct packed {
    logic       capture;      // latch new item, clear removed, set status
    logic [1:0] status_code;
    logic       inc_count;
    logic       dec_count;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       grab_removed; // removed <= read data
    logic       grab_cur;     // moving value <= read data
    logic       pos_root;
    logic       grab_left;
    logic       up_step;      // parent moves down into hole, hole moves up
    logic       dn_step;      // larger child moves up, hole moves down
    logic       place;        // moving value written into hole
    logic       load_result;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic left_ok;
    logic right_ok;
    logic up_gt;
    logic dn_gt;
  } dp_status_t;

endpackage

// ===== hw/rtl/binary_max_heap_queue_top.sv =====
// ----------------------------------------------------------------------------
// binary_max_heap_queue_top: max priority queue on a binary heap
// Inserts signed values or removes the maximum, one request at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with req_type/value while busy is low; the item is taken at
//   that edge. req_type selects insert (0) or remove maximum (1).
//   When the request is finished, done pulses for one cycle together with
//   status, removed_value, top_value and entry_count. The receiver cannot
//   stall; results must be taken in the done cycle. Outputs hold their last
//   values otherwise.
//   Each heap level the value moves (at most log2(CAPACITY) levels) needs a
//   read of the heap memory, a registered compare and a write-back (two reads
//   per level on the way down). Refused requests (insert when full, remove
//   when empty) skip the sift and go straight to the final root read.
//   busy drops in the done cycle, so a new start can be taken right then.
//   Reset (rst, synchronous, active high) empties the queue; the heap
//   memory itself is not cleared, only the entry count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_max_heap_queue_top
  import bmhq_pkg::*;
#(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32,
  parameter int CW          = $clog2(CAPACITY + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   req_type,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   done,
  output logic [1:0]             status,
  output logic [VALUE_WIDTH-1:0] removed_value,
  output logic [VALUE_WIDTH-1:0] top_value,
  output logic [CW-1:0]          entry_count
);

  // controller <-> datapath
  cmd_t       cmd;
  dp_status_t dp_status;

  // sequencer: one heap level per step
  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req_type  (req_type),
    .dp_status (dp_status),
    .cmd       (cmd),
    .busy      (busy)
  );

  // heap store, hole pointer, count and result registers
  bmhq_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH),
    .CW          (CW)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .value         (value),
    .dp_status     (dp_status),
    .done          (done),
    .status        (status),
    .removed_value (removed_value),
    .top_value     (top_value),
    .entry_count   (entry_count)
  );

endmodule

// ===== hw/rtl/bmhq_datapath.sv =====
// ----------------------------------------------------------------------------
// bmhq_datapath: heap store, count, hole pointer and result registers
// Single write / single registered read memory; sifts move a hole and keep
// the travelling value in a register until its final place is found.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmhq_datapath
  import bmhq_pkg::*;
#(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32,
  parameter int CW          = $clog2(CAPACITY + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  input  logic [VALUE_WIDTH-1:0] value,
  output dp_status_t             dp_status,
  output logic                   done,
  output logic [1:0]             status,
  output logic [VALUE_WIDTH-1:0] removed_value,
  output logic [VALUE_WIDTH-1:0] top_value,
  output logic [CW-1:0]          entry_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IW = CW + 1;

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] rdata;
  logic [VALUE_WIDTH-1:0] cur;
  logic [VALUE_WIDTH-1:0] lval;
  logic [VALUE_WIDTH-1:0] removed;
  logic [1:0]             status_r;
  logic [CW-1:0]          count;
  logic [AW-1:0]          pos;

  logic [CW-1:0]          cnt_m1;
  logic [AW-1:0]          parent;
  logic [IW-1:0]          lidx;
  logic [IW-1:0]          ridx;
  logic                   pick_right;
  logic [VALUE_WIDTH-1:0] pick_val;
  logic [AW-1:0]          raddr;
  logic                   we;
  logic [VALUE_WIDTH-1:0] wdata;

  assign cnt_m1     = count - CW'(1);
  assign parent     = AW'((pos - AW'(1)) >> 1);
  assign lidx       = IW'({pos, 1'b1});
  assign ridx       = lidx + IW'(1);
  assign pick_right = dp_status.right_ok && ($signed(rdata) > $signed(lval));
  assign pick_val   = pick_right ? rdata : lval;

  assign dp_status.full     = (count == CW'(CAPACITY));
  assign dp_status.empty    = (count == '0);
  assign dp_status.pos_zero = (pos == '0);
  assign dp_status.left_ok  = (lidx < {1'b0, count});
  assign dp_status.right_ok = (ridx < {1'b0, count});
  assign dp_status.up_gt    = ($signed(cur) > $signed(rdata));
  assign dp_status.dn_gt    = ($signed(pick_val) > $signed(cur));

  always_comb begin
    case (cmd.rd_sel)
      RD_ROOT:   raddr = '0;
      RD_LAST:   raddr = cnt_m1[AW-1:0];
      RD_PARENT: raddr = parent;
      RD_LEFT:   raddr = lidx[AW-1:0];
      RD_RIGHT:  raddr = ridx[AW-1:0];
      default:   raddr = '0;
    endcase
  end

  assign we = cmd.up_step | cmd.dn_step | cmd.place;

  always_comb begin
    if (cmd.up_step) begin
      wdata = rdata;
    end else if (cmd.dn_step) begin
      wdata = pick_val;
    end else begin
      wdata = cur;
    end
  end

  // heap store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[pos] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      if (cmd.inc_count) begin
        count <= count + CW'(1);
      end else if (cmd.dec_count) begin
        count <= cnt_m1;
      end
      done <= cmd.load_result;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur      <= value;
      pos      <= count[AW-1:0];
      removed  <= '0;
      status_r <= cmd.status_code;
    end
    if (cmd.grab_removed) begin
      removed <= rdata;
    end
    if (cmd.grab_cur) begin
      cur <= rdata;
    end
    if (cmd.pos_root) begin
      pos <= '0;
    end
    if (cmd.grab_left) begin
      lval <= rdata;
    end
    if (cmd.up_step) begin
      pos <= parent;
    end
    if (cmd.dn_step) begin
      pos <= pick_right ? ridx[AW-1:0] : lidx[AW-1:0];
    end
    if (cmd.load_result) begin
      status        <= status_r;
      removed_value <= removed;
      top_value     <= dp_status.empty ? '0 : rdata;
      entry_count   <= count;
    end
  end

endmodule

// ===== hw/rtl/bmhq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmhq_ctrl: sequencer for insert / remove requests
// Steps the datapath through sift-up or sift-down one heap level at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       req_type,
  input  dp_status_t dp_status,
  output cmd_t       cmd,
  output logic       busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_ROOT;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          if (req_type == REQ_INSERT) begin
            if (dp_status.full) begin
              cmd.status_code = ST_FULL;
              state_next      = S_FIN_RD;
            end else begin
              cmd.status_code = ST_OK;
              cmd.inc_count   = 1'b1;
              state_next      = S_UP_CHK;
            end
          end else begin
            if (dp_status.empty) begin
              cmd.status_code = ST_EMPTY;
              state_next      = S_FIN_RD;
            end else begin
              cmd.status_code = ST_OK;
              state_next      = S_DN_ROOT;
            end
          end
        end
      end
      S_UP_CHK: begin
        if (dp_status.pos_zero) begin
          cmd.place  = 1'b1;
          state_next = S_FIN_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PARENT;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (dp_status.up_gt) begin
          cmd.up_step = 1'b1;
          state_next  = S_UP_CHK;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_FIN_RD;
        end
      end
      S_DN_ROOT: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_ROOT;
        state_next = S_DN_LAST;
      end
      S_DN_LAST: begin
        cmd.grab_removed = 1'b1;
        cmd.rd_en        = 1'b1;
        cmd.rd_sel       = RD_LAST;
        cmd.dec_count    = 1'b1;
        cmd.pos_root     = 1'b1;
        state_next       = S_DN_GRAB;
      end
      S_DN_GRAB: begin
        cmd.grab_cur = 1'b1;
        state_next   = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (!dp_status.left_ok) begin
          cmd.place  = 1'b1;
          state_next = S_FIN_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LEFT;
          state_next = S_DN_RR;
        end
      end
      S_DN_RR: begin
        cmd.grab_left = 1'b1;
        cmd.rd_en     = dp_status.right_ok;
        cmd.rd_sel    = RD_RIGHT;
        state_next    = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (dp_status.dn_gt) begin
          cmd.dn_step = 1'b1;
          state_next  = S_DN_CHK;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_FIN_RD;
        end
      end
      S_FIN_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_ROOT;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.load_result = 1'b1;
        state_next      = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
